>>> hdl/rsq_pkg.sv
package rsq_pkg;

	// Field widths of the stream beats
	localparam int STREAM_W = 2;
	localparam int SEQ_W    = 32;
	localparam int HANDLE_W = 16;
	localparam int STATUS_W = 2;
	localparam int FIELDS_W = STREAM_W + SEQ_W + HANDLE_W;
	localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

	// Default configuration of the top level
	localparam int WINDOW_DEF      = 16;
	localparam int NUM_STREAMS_DEF = 4;
	localparam int HANDLE_BITS_DEF = 16;

	// Result status codes as they leave on tuser
	typedef enum logic [STATUS_W-1:0] {
		ST_RELEASED  = 2'd0,
		ST_STALE     = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_BEYOND    = 2'd3
	} status_t;

	// Position of a segment relative to the expected sequence number
	typedef enum logic [1:0] {
		POS_INORDER,
		POS_EARLY,
		POS_STALE,
		POS_BEYOND
	} pos_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_REJ,
		S_REL
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic take;
		logic eval;
		logic store;
		logic emit_rej;
		logic emit_rel;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic in_fire;
		logic bad_stream;
		pos_t pos;
		logic dup;
		logic out_free;
		logic more;
	} sts_t;

endpackage

>>> hdl/rsq_ctrl.sv
module rsq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  rsq_pkg::sts_t sts,
	output rsq_pkg::cmd_t cmd
);

	rsq_pkg::state_t state_q;
	rsq_pkg::state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsq_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			rsq_pkg::S_IDLE: begin
				cmd.take = 1'b1;
				if (sts.in_fire) begin
					state_nxt = rsq_pkg::S_EVAL;
				end
			end
			rsq_pkg::S_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.bad_stream) begin
					state_nxt = rsq_pkg::S_IDLE;
				end else begin
					case (sts.pos)
						rsq_pkg::POS_INORDER: begin
							state_nxt = rsq_pkg::S_REL;
						end
						rsq_pkg::POS_EARLY: begin
							if (sts.dup) begin
								state_nxt = rsq_pkg::S_REJ;
							end else begin
								cmd.store = 1'b1;
								state_nxt = rsq_pkg::S_IDLE;
							end
						end
						default: begin
							state_nxt = rsq_pkg::S_REJ;
						end
					endcase
				end
			end
			rsq_pkg::S_REJ: begin
				if (sts.out_free) begin
					cmd.emit_rej = 1'b1;
					state_nxt    = rsq_pkg::S_IDLE;
				end
			end
			rsq_pkg::S_REL: begin
				if (sts.out_free) begin
					cmd.emit_rel = 1'b1;
					if (!sts.more) begin
						state_nxt = rsq_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = rsq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/rsq_dp.sv
module rsq_dp #(
	parameter int WINDOW      = rsq_pkg::WINDOW_DEF,
	parameter int NUM_STREAMS = rsq_pkg::NUM_STREAMS_DEF,
	parameter int HANDLE_BITS = rsq_pkg::HANDLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rsq_pkg::cmd_t                cmd,
	output rsq_pkg::sts_t                sts,
	input  logic                         in_tvalid,
	input  logic [rsq_pkg::TDATA_W-1:0]  in_tdata,
	output logic                         out_tvalid,
	input  logic                         out_tready,
	output logic [rsq_pkg::TDATA_W-1:0]  out_tdata,
	output logic [rsq_pkg::STATUS_W-1:0] out_tuser,
	output logic                         out_tlast
);

	// Streams beyond what the stream field can address are never stored
	localparam int NS    = (NUM_STREAMS < (1 << rsq_pkg::STREAM_W)) ? NUM_STREAMS
		: (1 << rsq_pkg::STREAM_W);
	localparam int SIW   = (NS > 1) ? $clog2(NS) : 1;
	localparam int SLW   = $clog2(WINDOW);
	localparam int HB    = (HANDLE_BITS < rsq_pkg::HANDLE_W) ? HANDLE_BITS : rsq_pkg::HANDLE_W;
	localparam int DEPTH = NS * WINDOW;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(WINDOW + 1);
	localparam int SW    = rsq_pkg::STREAM_W;
	localparam int QW    = rsq_pkg::SEQ_W;
	localparam int PAD_W = rsq_pkg::TDATA_W - rsq_pkg::FIELDS_W;

	// Latched input segment
	logic [SW-1:0]  stream_q;
	logic [QW-1:0]  seq_q;
	logic [HB-1:0]  hnd_q;

	// Per-stream expected number and its slot in the window
	logic [QW-1:0]     exp_q   [NS];
	logic [SLW-1:0]    eslot_q [NS];
	logic [WINDOW-1:0] valid_q [NS];

	// Held handles
	logic [HB-1:0] mem [DEPTH];
	logic [HB-1:0] rd_q;

	// Burst bookkeeping and rejection status
	logic [CW-1:0]    cnt_q;
	logic             first_q;
	rsq_pkg::status_t rej_st_q;

	// Output register
	logic             oval_q;
	logic [SW-1:0]    ostream_q;
	logic [QW-1:0]    oseq_q;
	logic [HB-1:0]    ohnd_q;
	rsq_pkg::status_t ost_q;
	logic             olast_q;

	logic [SIW-1:0]  sidx;
	logic [QW-1:0]   exp_cur;
	logic [SLW-1:0]  slot_cur;
	logic [QW-1:0]   diff;
	logic [SLW:0]    esum;
	logic [SLW-1:0]  eslot;
	logic [SLW-1:0]  nslot;
	logic [AW-1:0]   waddr;
	logic [AW-1:0]   raddr;
	logic [HB-1:0]   hnd_cur;
	logic            more;
	rsq_pkg::pos_t   pos;

	localparam logic [AW-1:0] WIN_A = AW'(WINDOW);

	// Classification of the latched segment against its stream
	always_comb begin
		sidx     = stream_q[SIW-1:0];
		exp_cur  = exp_q[sidx];
		slot_cur = eslot_q[sidx];
		diff     = seq_q - exp_cur;
		if (diff == '0) begin
			pos = rsq_pkg::POS_INORDER;
		end else if (diff < QW'(WINDOW)) begin
			pos = rsq_pkg::POS_EARLY;
		end else if (diff[QW-1]) begin
			pos = rsq_pkg::POS_STALE;
		end else begin
			pos = rsq_pkg::POS_BEYOND;
		end
		// Slot of an early segment: expected slot plus a distance below the window
		esum = {1'b0, slot_cur} + {1'b0, diff[SLW-1:0]};
		if (esum >= (SLW + 1)'(WINDOW)) begin
			eslot = SLW'(esum - (SLW + 1)'(WINDOW));
		end else begin
			eslot = esum[SLW-1:0];
		end
		if (slot_cur == SLW'(WINDOW - 1)) begin
			nslot = '0;
		end else begin
			nslot = slot_cur + SLW'(1);
		end
		more    = valid_q[sidx][nslot] && (cnt_q < CW'(WINDOW - 1));
		waddr   = AW'(sidx) * WIN_A + AW'(eslot);
		raddr   = AW'(sidx) * WIN_A + AW'(nslot);
		hnd_cur = first_q ? hnd_q : rd_q;
	end

	// Status towards the controller
	always_comb begin
		sts.in_fire    = cmd.take && in_tvalid;
		sts.bad_stream = {1'b0, stream_q} >= (SW + 1)'(NS);
		sts.pos        = pos;
		sts.dup        = valid_q[sidx][eslot];
		sts.out_free   = !oval_q || out_tready;
		sts.more       = more;
	end

	// Stream state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				exp_q[i]   <= '0;
				eslot_q[i] <= '0;
				valid_q[i] <= '0;
			end
			oval_q <= 1'b0;
		end else begin
			if (cmd.store) begin
				valid_q[sidx][eslot] <= 1'b1;
			end
			if (cmd.emit_rel) begin
				valid_q[sidx][slot_cur] <= 1'b0;
				exp_q[sidx]             <= exp_cur + QW'(1);
				eslot_q[sidx]           <= nslot;
			end
			if (cmd.emit_rej || cmd.emit_rel) begin
				oval_q <= 1'b1;
			end else if (out_tready) begin
				oval_q <= 1'b0;
			end
		end
	end

	// Input latch, burst counter and result payload
	always_ff @(posedge clk) begin
		if (sts.in_fire) begin
			stream_q <= in_tdata[SW-1:0];
			seq_q    <= in_tdata[SW +: QW];
			hnd_q    <= in_tdata[SW + QW +: HB];
		end
		if (cmd.eval) begin
			cnt_q   <= '0;
			first_q <= 1'b1;
			case (pos)
				rsq_pkg::POS_STALE:  rej_st_q <= rsq_pkg::ST_STALE;
				rsq_pkg::POS_BEYOND: rej_st_q <= rsq_pkg::ST_BEYOND;
				default:             rej_st_q <= rsq_pkg::ST_DUPLICATE;
			endcase
		end
		if (cmd.emit_rej) begin
			ostream_q <= stream_q;
			oseq_q    <= seq_q;
			ohnd_q    <= hnd_q;
			ost_q     <= rej_st_q;
			olast_q   <= 1'b1;
		end
		if (cmd.emit_rel) begin
			ostream_q <= stream_q;
			oseq_q    <= exp_cur;
			ohnd_q    <= hnd_cur;
			ost_q     <= rsq_pkg::ST_RELEASED;
			olast_q   <= !more;
			cnt_q     <= cnt_q + CW'(1);
			first_q   <= 1'b0;
		end
	end

	// Handle memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[waddr] <= hnd_q;
		end
		if (cmd.emit_rel && more) begin
			rd_q <= mem[raddr];
		end
	end

	assign out_tvalid = oval_q;
	assign out_tdata  = {PAD_W'(0), rsq_pkg::HANDLE_W'(ohnd_q), oseq_q, ostream_q};
	assign out_tuser  = ost_q;
	assign out_tlast  = olast_q;

endmodule

>>> hdl/segment_resequencer.sv
// Per-stream sequence-number resequencer.
// Input beats on s_axis carry a stream number, a sequence number and a buffer
// handle. Results leave on m_axis: the stream, the sequence number and the
// handle in tdata, the status in tuser and the final result of a beat on tlast.
// An accepted beat is latched and evaluated in the EVAL state; a single result
// (a rejection, or the first release) is then loaded into the output register
// as soon as it is free and is visible on m_axis from then on. A held early
// segment gives no result and the block returns to idle after evaluation.
// A release burst leaves one result a cycle while m_axis_tready does not stall;
// the burst is paced by the single read port of the handle memory, one held
// slot per cycle.
// s_axis_tready is high only while the controller is idle, and it is high
// again while the last result of the previous beat still waits in the output
// register.
// Reset sets every expected number to zero and clears all slot valid flags;
// no clearing pass follows. A stall on m_axis_tready holds the output
// register and pauses the drain without losing a result.
module segment_resequencer #(
	parameter int WINDOW      = rsq_pkg::WINDOW_DEF,
	parameter int NUM_STREAMS = rsq_pkg::NUM_STREAMS_DEF,
	parameter int HANDLE_BITS = rsq_pkg::HANDLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// stream[1:0], seq_number[33:2], segment_handle[49:34], zero fill
	input  logic [rsq_pkg::TDATA_W-1:0]  s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// out_stream[1:0], out_seq[33:2], out_handle[49:34], zero fill
	output logic [rsq_pkg::TDATA_W-1:0]  m_axis_tdata,
	// status[1:0]
	output logic [rsq_pkg::STATUS_W-1:0] m_axis_tuser,
	output logic                         m_axis_tlast
);

	rsq_pkg::cmd_t cmd;
	rsq_pkg::sts_t sts;

	// Controller
	rsq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Datapath with stream state, slot flags and handle memory
	rsq_dp #(
		.WINDOW      (WINDOW),
		.NUM_STREAMS (NUM_STREAMS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_tvalid  (s_axis_tvalid),
		.in_tdata   (s_axis_tdata),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.out_tdata  (m_axis_tdata),
		.out_tuser  (m_axis_tuser),
		.out_tlast  (m_axis_tlast)
	);

	assign s_axis_tready = cmd.take;

	// A rejection is always the only result of its beat.
	a_rej_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != rsq_pkg::ST_RELEASED) |-> m_axis_tlast)
		else $error("rejected result without tlast");

	// One beat is taken at a time.
	a_take_once: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a beat is in work");

	// The controller never stores and emits in the same cycle.
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.store, cmd.emit_rej, cmd.emit_rel}))
		else $error("conflicting datapath commands");

	// Inside a release burst each result follows the previous number.
	a_burst_seq: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast
		&& (m_axis_tuser == rsq_pkg::ST_RELEASED)
		|=> m_axis_tvalid && (m_axis_tdata[33:2] == $past(m_axis_tdata[33:2]) + 32'd1))
		else $error("release burst out of order");

endmodule
